@@ sv/txrc_pkg.sv @@
package txrc_pkg;

    localparam int DEF_BUFFER_DEPTH = 2048;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int RIDX_W  = 11;
    localparam int ADDR_W  = 11;
    localparam int LEN_W   = 12;
    localparam int MAX_RIDX = (1 << RIDX_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_DONE  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RETIRE,
        ST_START,
        ST_REDUCE,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_message;
        logic [RIDX_W-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic              byte_accepted;
        logic              start_valid;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  start_length;
        logic [BYTE_W-1:0] read_data;
        logic [LEN_W-1:0]  bytes_waiting;
    } result_t;

    typedef struct packed {
        logic capture;
        logic write;
        logic retire;
        logic start;
        logic reduce;
        logic mem_rd;
        logic rd_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            last;
        logic            reduce_done;
    } status_t;

endpackage

@@ sv/txrc_chan_if.sv @@
interface txrc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ sv/txrc_ctrl.sv @@
module txrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  txrc_pkg::status_t status,
    output txrc_pkg::cmd_t    cmd
);
    import txrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op_t'(status.op))
                        OP_WRITE: state_next = ST_WRITE;
                        OP_DONE:  state_next = ST_RETIRE;
                        OP_READ:  state_next = ST_REDUCE;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_WRITE:   state_next = status.last ? ST_START : ST_OUT;
            ST_RETIRE:  state_next = ST_START;
            ST_START:   state_next = ST_OUT;
            ST_REDUCE:  state_next = status.reduce_done ? ST_RD_MEM : ST_REDUCE;
            ST_RD_MEM:  state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_OUT;
            ST_OUT:     state_next = out_ready ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_WRITE:   cmd.write   = 1'b1;
            ST_RETIRE:  cmd.retire  = 1'b1;
            ST_START:   cmd.start   = 1'b1;
            ST_REDUCE:  cmd.reduce  = 1'b1;
            ST_RD_MEM:  cmd.mem_rd  = 1'b1;
            ST_RD_DATA: cmd.rd_load = 1'b1;
            ST_OUT:     out_valid   = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

@@ sv/txrc_dpath.sv @@
module txrc_dpath #(
    parameter int BUFFER_DEPTH = txrc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  txrc_pkg::item_t   item,
    input  txrc_pkg::cmd_t    cmd,
    output txrc_pkg::status_t status,
    output txrc_pkg::result_t result
);
    import txrc_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam bit RED_ON   = (BUFFER_DEPTH <= MAX_RIDX);
    localparam int RECIP_SH = RIDX_W + $clog2(BUFFER_DEPTH);
    localparam int RECIP    = ((1 << RECIP_SH) + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

    item_t             item_reg;
    logic [IDX_W-1:0]  w_idx_reg, w_idx_next;
    logic              w_ph_reg, w_ph_next;
    logic [IDX_W-1:0]  r_idx_reg, r_idx_next;
    logic              r_ph_reg, r_ph_next;
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  chunk_reg, chunk_next;

    logic              acc_reg;
    logic              sv_reg;
    logic [ADDR_W-1:0] saddr_reg;
    logic [LEN_W-1:0]  slen_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] mem_q_reg;
    logic [RIDX_W-1:0] red_reg;
    logic [RIDX_W-1:0] quo_reg;
    logic              step_reg;

    logic [CNT_W-1:0]  w_ext, r_ext;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  run;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  retire_sum;
    logic              full;
    logic              can_start;
    logic [31:0]       used_32, len_32, raddr_32, red_32;
    logic [31:0]       prod_32, quo_32, rem_32;
    logic [IDX_W-1:0]  rd_idx;

    assign w_ext = CNT_W'(w_idx_reg);
    assign r_ext = CNT_W'(r_idx_reg);
    assign used  = (w_ph_reg == r_ph_reg) ? (w_ext - r_ext) : (DEPTH_C - r_ext + w_ext);
    assign full  = (used == DEPTH_C);
    assign run   = DEPTH_C - r_ext;
    assign len   = (used < run) ? used : run;
    assign can_start  = !busy_reg && (used != '0);
    assign retire_sum = r_ext + chunk_reg;

    assign used_32  = 32'(used);
    assign len_32   = 32'(len);
    assign raddr_32 = 32'(r_idx_reg);
    assign red_32   = 32'(red_reg);
    assign prod_32  = red_32 * 32'(RECIP);
    assign quo_32   = prod_32 >> RECIP_SH;
    assign rem_32   = red_32 - 32'(quo_reg) * 32'(BUFFER_DEPTH);
    assign rd_idx   = red_32[IDX_W-1:0];

    always_comb
    begin
        w_idx_next = w_idx_reg;
        w_ph_next  = w_ph_reg;
        r_idx_next = r_idx_reg;
        r_ph_next  = r_ph_reg;
        busy_next  = busy_reg;
        chunk_next = chunk_reg;
        if (cmd.write && !full)
        begin
            if (w_idx_reg == LAST_IDX)
            begin
                w_idx_next = '0;
                w_ph_next  = !w_ph_reg;
            end
            else
            begin
                w_idx_next = w_idx_reg + 1'b1;
            end
        end
        if (cmd.retire && busy_reg)
        begin
            busy_next = 1'b0;
            if (retire_sum == DEPTH_C)
            begin
                r_idx_next = '0;
                r_ph_next  = !r_ph_reg;
            end
            else
            begin
                r_idx_next = retire_sum[IDX_W-1:0];
            end
        end
        if (cmd.start && can_start)
        begin
            busy_next  = 1'b1;
            chunk_next = len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_idx_reg <= '0;
            w_ph_reg  <= 1'b0;
            r_idx_reg <= '0;
            r_ph_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            chunk_reg <= '0;
        end
        else
        begin
            w_idx_reg <= w_idx_next;
            w_ph_reg  <= w_ph_next;
            r_idx_reg <= r_idx_next;
            r_ph_reg  <= r_ph_next;
            busy_reg  <= busy_next;
            chunk_reg <= chunk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg  <= item;
            acc_reg   <= 1'b0;
            sv_reg    <= 1'b0;
            saddr_reg <= '0;
            slen_reg  <= '0;
            rdata_reg <= '0;
            red_reg   <= item.read_index;
            step_reg  <= 1'b1;
        end
        if (cmd.write && !full)
        begin
            acc_reg <= 1'b1;
        end
        if (cmd.start && can_start)
        begin
            sv_reg    <= 1'b1;
            saddr_reg <= raddr_32[ADDR_W-1:0];
            slen_reg  <= len_32[LEN_W-1:0];
        end
        // read index modulo depth: reciprocal quotient, then remainder
        if (cmd.reduce && RED_ON)
        begin
            if (step_reg)
            begin
                quo_reg  <= quo_32[RIDX_W-1:0];
                step_reg <= 1'b0;
            end
            else
            begin
                red_reg <= rem_32[RIDX_W-1:0];
            end
        end
        if (cmd.rd_load)
        begin
            rdata_reg <= mem_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && !full)
        begin
            mem[w_idx_reg] <= item_reg.data_byte;
        end
        if (cmd.mem_rd)
        begin
            mem_q_reg <= mem[rd_idx];
        end
    end

    assign status.op          = item.operation;
    assign status.last        = item_reg.last_of_message;
    assign status.reduce_done = !RED_ON || !step_reg;

    assign result.byte_accepted = acc_reg;
    assign result.start_valid   = sv_reg;
    assign result.start_address = saddr_reg;
    assign result.start_length  = slen_reg;
    assign result.read_data     = rdata_reg;
    assign result.bytes_waiting = used_32[LEN_W-1:0];

endmodule

@@ sv/tx_ring_dma_chunker.sv @@
// channel | dir | payload  | handshake
// req     | in  | item_t   | valid/ready, word taken when both high
// rsp     | out | result_t | valid/ready, word taken when both high
//
// One word at a time: capture, then write (plus start on a message's last byte),
// done retire and start, unused op none, read reduce, memory read and data load; the
// reduction works only when BUFFER_DEPTH < 2048 (index modulo depth: reciprocal
// quotient, then subtract), then rsp until taken. The buffer is a single-port byte memory.
// Reset clears pointers, busy flag and FSM; the memory is not cleared.
// A stalled rsp holds the result and keeps req.ready low.
module tx_ring_dma_chunker #(
    parameter int BUFFER_DEPTH = txrc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    txrc_chan_if.sink   req,
    txrc_chan_if.source rsp
);
    import txrc_pkg::*;

    cmd_t    cmd;
    status_t status;
    item_t   item;
    result_t result;

    assign item     = req.data;
    assign rsp.data = result;

    txrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    txrc_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
